/* rtl/core/blg_pkg.sv */
// Bresenham line generator: shared widths, command codes and record types.
// No dependencies; every other file of the block imports this package.
package blg_pkg;

  // Field widths
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COORD_W = 9;   // major / minor axis positions
  localparam int OFS_W   = 17;
  localparam int COLOR_W = 16;
  localparam int ERR_W   = 11;  // signed error accumulator

  // Framebuffer row pitch as a shift
  localparam int ROW_SHIFT = 9;

  // Command codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Line walker state
  typedef struct packed {
    logic               active;
    logic               steep;
    logic [COORD_W-1:0] major_pos;
    logic [COORD_W-1:0] major_stop;
    logic [COORD_W-1:0] minor_pos;
    logic [COORD_W-1:0] major_delta;
    logic [COORD_W-1:0] minor_delta;
    logic               step_down;
    logic [ERR_W-1:0]   err;
    logic [COLOR_W-1:0] color;
  } blg_state_t;

  // One emitted pixel
  typedef struct packed {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [OFS_W-1:0]   offset;
    logic [COLOR_W-1:0] color;
    logic               last;
  } blg_pixel_t;

endpackage

/* rtl/core/blg_if.sv */
// Valid/ready channel interfaces for the line generator: commands in, pixels out.
// Depends on blg_pkg for field widths.
interface blg_cmd_if import blg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [X_W-1:0]     start_x;
  logic [Y_W-1:0]     start_y;
  logic [X_W-1:0]     end_x;
  logic [Y_W-1:0]     end_y;
  logic [COLOR_W-1:0] line_color;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

interface blg_pix_if import blg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [X_W-1:0]     pixel_x;
  logic [Y_W-1:0]     pixel_y;
  logic [OFS_W-1:0]   pixel_offset;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_offset, pixel_color, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_offset, pixel_color, last_pixel,
                  output ready);
endinterface

/* rtl/core/bresenham_line_pixel_generator.sv */
// Bresenham line pixel generator, top level: walker state, output register, handshake.
// Depends on blg_pkg, blg_if (blg_cmd_if, blg_pix_if) and blg_step.
//
//   channel  | dir | handshake    | carries
//   ---------+-----+--------------+-------------------------------------------------
//   in_ch    | in  | valid/ready  | opcode, start_x, start_y, end_x, end_y, line_color
//   out_ch   | out | valid/ready  | pixel_x, pixel_y, pixel_offset, pixel_color, last_pixel
//
// One command per unstalled clock; a tick's pixel is on out_ch the cycle after acceptance.
// The walker state register and the pixel output register bound the single step path.
// in_ch.ready drops only while a pixel sits in the output register and out_ch is stalled.
// Reset (rst_n low, synchronous) leaves the block idle with the output register empty.
module bresenham_line_pixel_generator import blg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  blg_cmd_if.sink   in_ch,
  blg_pix_if.source out_ch
);

  blg_state_t st_r, st_nxt, step_st;
  blg_pixel_t pix, out_pix_r;
  logic       emit;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  blg_step u_step (
    .st         (st_r),
    .opcode     (in_ch.opcode),
    .start_x    (in_ch.start_x),
    .start_y    (in_ch.start_y),
    .end_x      (in_ch.end_x),
    .end_y      (in_ch.end_y),
    .line_color (in_ch.line_color),
    .st_nxt     (step_st),
    .pix        (pix),
    .emit       (emit)
  );

  // Handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign st_nxt        = in_fire ? step_st : st_r;
  assign out_valid_nxt = (in_fire && emit) || (out_valid_r && !out_ch.ready);

  // Walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_pix_r <= pix;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_pix_r.x;
  assign out_ch.pixel_y      = out_pix_r.y;
  assign out_ch.pixel_offset = out_pix_r.offset;
  assign out_ch.pixel_color  = out_pix_r.color;
  assign out_ch.last_pixel   = out_pix_r.last;

`ifndef SYNTH
  // walker never runs past the far endpoint
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active |-> (st_r.major_pos <= st_r.major_stop))
    else $error("major position beyond line end");

  // error accumulator stays at or below zero
  a_err_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active |-> ($signed(st_r.err) <= $signed(ERR_W'(0))))
    else $error("error accumulator positive");

  // last pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == OP_TICK && st_r.active &&
     st_r.major_pos == st_r.major_stop) |=> !st_r.active)
    else $error("line still active after last pixel");

  // an empty output register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output register");
`endif

endmodule

/* rtl/core/blg_step.sv */
// One Bresenham step: line setup on a start command, one pixel plus advance on a tick.
// Purely combinational; depends on blg_pkg.
module blg_step import blg_pkg::*; (
  input  blg_state_t          st,
  input  logic                opcode,
  input  logic [X_W-1:0]      start_x,
  input  logic [Y_W-1:0]      start_y,
  input  logic [X_W-1:0]      end_x,
  input  logic [Y_W-1:0]      end_y,
  input  logic [COLOR_W-1:0]  line_color,
  output blg_state_t          st_nxt,
  output blg_pixel_t          pix,
  output logic                emit
);

  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COORD_W-1:0] dx, dy;
  logic               steep;
  logic [COORD_W-1:0] a0, b0, a1, b1;
  logic [COORD_W-1:0] lo_a, lo_b, hi_a, hi_b;
  logic [COORD_W-1:0] maj_d;
  logic [COORD_W-1:0] px, py;
  logic               last;
  logic [ERR_W-1:0]   err_add;

  // Setup: steepness, axis swap, ordering along the major axis
  always_comb begin
    sx = COORD_W'(start_x);
    sy = COORD_W'(start_y);
    ex = COORD_W'(end_x);
    ey = COORD_W'(end_y);
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    steep = dy > dx;
    a0 = steep ? sy : sx;
    b0 = steep ? sx : sy;
    a1 = steep ? ey : ex;
    b1 = steep ? ex : ey;
    if (a0 > a1) begin
      lo_a = a1; lo_b = b1; hi_a = a0; hi_b = b0;
    end else begin
      lo_a = a0; lo_b = b0; hi_a = a1; hi_b = b1;
    end
    maj_d = hi_a - lo_a;
  end

  // Tick: current pixel and its offset
  always_comb begin
    px   = st.steep ? st.minor_pos : st.major_pos;
    py   = st.steep ? st.major_pos : st.minor_pos;
    last = st.major_pos == st.major_stop;
    pix.x      = px;
    pix.y      = py[Y_W-1:0];
    pix.offset = OFS_W'(px) + (OFS_W'(py[Y_W-1:0]) << ROW_SHIFT);
    pix.color  = st.color;
    pix.last   = last;
    err_add    = st.err + ERR_W'(st.minor_delta);
  end

  // Next state
  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    if (opcode == OP_START) begin
      st_nxt.active      = 1'b1;
      st_nxt.steep       = steep;
      st_nxt.major_pos   = lo_a;
      st_nxt.major_stop  = hi_a;
      st_nxt.minor_pos   = lo_b;
      st_nxt.major_delta = maj_d;
      st_nxt.minor_delta = (hi_b > lo_b) ? hi_b - lo_b : lo_b - hi_b;
      st_nxt.step_down   = lo_b > hi_b;
      st_nxt.err         = ERR_W'(0) - ERR_W'(maj_d[COORD_W-1:1]);
      st_nxt.color       = line_color;
    end else if (st.active) begin
      emit = 1'b1;
      if (last) begin
        st_nxt.active = 1'b0;
      end else begin
        st_nxt.major_pos = st.major_pos + COORD_W'(1);
        st_nxt.err       = err_add;
        // minor axis steps only on a strictly positive error
        if ($signed(err_add) > $signed(ERR_W'(0))) begin
          st_nxt.minor_pos = st.step_down ? st.minor_pos - COORD_W'(1)
                                          : st.minor_pos + COORD_W'(1);
          st_nxt.err       = err_add - ERR_W'(st.major_delta);
        end
      end
    end
  end

endmodule
